/* hw/rtl/xml_escape_utf8_to_char_ref_defines.svh */
// ----------------------------------------------------------------------------
// XML escaper assertion macros
// Shared property shorthands for the checker; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef XML_ESCAPE_UTF8_TO_CHAR_REF_DEFINES_SVH
`define XML_ESCAPE_UTF8_TO_CHAR_REF_DEFINES_SVH

// same-cycle implication
`define XESC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define XESC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/xesc_pkg.sv */
// ----------------------------------------------------------------------------
// XML escaper package
// Types, character codes and helpers shared by controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xesc_pkg;

  localparam int CP_W     = 21;
  localparam int ITEM_N   = 4;
  localparam int HELD_N   = 3;
  localparam int DIG_N    = 7;
  localparam int PROD_W   = 2 * CP_W;
  localparam int RECIP_SH = 24;

  localparam logic [CP_W-1:0] RECIP = 21'h19999A;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_ZERO = 8'h30;

  localparam logic [7:0] MASK_2B  = 8'hE0;
  localparam logic [7:0] LEAD_2B  = 8'hC0;
  localparam logic [7:0] MASK_3B  = 8'hF0;
  localparam logic [7:0] LEAD_3B  = 8'hE0;
  localparam logic [7:0] MASK_4B  = 8'hF8;
  localparam logic [7:0] LEAD_4B  = 8'hF0;

  typedef enum logic [2:0] {
    SRC_PLAIN,
    SRC_AMP,
    SRC_HASH,
    SRC_DIGIT,
    SRC_SEMI
  } src_t;

  typedef struct packed {
    logic            is_ref;
    logic [CP_W-1:0] val;
  } item_t;

  typedef struct packed {
    logic load;
    logic conv_load;
    logic conv_step;
    logic push;
    src_t src;
    logic item_next;
  } cmd_t;

  typedef struct packed {
    logic build_empty;
    logic item_ref;
    logic item_last;
    logic conv_last;
    logic dig_last;
    logic slot_free;
  } sts_t;

  function automatic logic [2:0] seq_len(input logic [7:0] lead);
    logic [2:0] n;
    n = 3'd0;
    if ((lead & MASK_2B) == LEAD_2B) n = 3'd2;
    else if ((lead & MASK_3B) == LEAD_3B) n = 3'd3;
    else if ((lead & MASK_4B) == LEAD_4B) n = 3'd4;
    return n;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/xesc_ctrl.sv */
// ----------------------------------------------------------------------------
// XML escaper controller
// Sequences item dispatch, decimal conversion and byte emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xesc_ctrl
  import xesc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_valid,
  output logic      ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ITEM,
    S_CONV,
    S_AMP,
    S_HASH,
    S_DIGIT,
    S_SEMI
  } state_t;

  state_t state, state_next;

  assign ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_valid) begin
          cmd.load = 1'b1;
          if (!sts.build_empty) state_next = S_ITEM;
        end
      end
      S_ITEM: begin
        if (sts.item_ref) begin
          cmd.conv_load = 1'b1;
          state_next    = S_CONV;
        end else if (sts.slot_free) begin
          cmd.push = 1'b1;
          cmd.src  = SRC_PLAIN;
          if (sts.item_last) state_next = S_IDLE;
          else cmd.item_next = 1'b1;
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_last) state_next = S_AMP;
      end
      S_AMP: begin
        if (sts.slot_free) begin
          cmd.push   = 1'b1;
          cmd.src    = SRC_AMP;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.slot_free) begin
          cmd.push   = 1'b1;
          cmd.src    = SRC_HASH;
          state_next = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (sts.slot_free) begin
          cmd.push = 1'b1;
          cmd.src  = SRC_DIGIT;
          if (sts.dig_last) state_next = S_SEMI;
        end
      end
      S_SEMI: begin
        if (sts.slot_free) begin
          cmd.push = 1'b1;
          cmd.src  = SRC_SEMI;
          if (sts.item_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.item_next = 1'b1;
            state_next    = S_ITEM;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/xesc_dpath.sv */
// ----------------------------------------------------------------------------
// XML escaper datapath
// Held sequence bytes, item list, decimal converter and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xesc_dpath
  import xesc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] in_byte,
  input  wire logic       utf8_mode,
  input  wire logic       string_end,
  input  wire cmd_t       cmd,
  output sts_t            sts,
  output logic            m_valid,
  input  wire logic       m_ready,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            text_done
);

  logic [7:0]      held [HELD_N];
  logic [1:0]      hc;
  item_t           items [ITEM_N];
  logic [2:0]      nitems;
  logic [1:0]      idx;
  logic            end_r;
  logic [CP_W-1:0] conv_val;
  logic [3:0]      digs [DIG_N];
  logic [2:0]      ndig;

  // sequence decode
  logic [2:0]      need;
  logic            brk, cont, complete, extend;
  logic            is_esc, fresh_do, fresh_plain, fresh_hold;
  logic [7:0]      held_upd [HELD_N];
  logic [2:0]      nflush;
  logic            tail_v;
  item_t           tail;
  logic [CP_W-1:0] cp;
  item_t           items_b [ITEM_N];
  logic [2:0]      nitems_b;
  logic [1:0]      hc_next;

  always_comb begin
    need     = seq_len(held[0]);
    brk      = (hc != 2'd0) && (!utf8_mode || (in_byte[7:6] != 2'b10));
    cont     = (hc != 2'd0) && !brk;
    complete = cont && (({1'b0, hc} + 3'd1) == need);
    extend   = cont && !complete;

    for (int i = 0; i < HELD_N; i++) begin
      held_upd[i] = held[i];
      if (extend && (hc == 2'(i))) held_upd[i] = in_byte;
    end

    if (brk) nflush = {1'b0, hc};
    else if (extend && string_end) nflush = {1'b0, hc} + 3'd1;
    else nflush = 3'd0;

    is_esc = (in_byte == CH_AMP) || (in_byte == CH_LT) || (in_byte == CH_GT) ||
             (in_byte == CH_APOS) || (in_byte == CH_QUOT);
    fresh_do    = !cont;
    fresh_plain = !is_esc && (!utf8_mode || !in_byte[7]);
    fresh_hold  = !is_esc && !fresh_plain && (seq_len(in_byte) != 3'd0) &&
                  !string_end;

    case (need)
      3'd2:    cp = CP_W'({held[0][4:0], in_byte[5:0]});
      3'd3:    cp = CP_W'({held[0][3:0], held[1][5:0], in_byte[5:0]});
      3'd4:    cp = {held[0][2:0], held[1][5:0], held[2][5:0], in_byte[5:0]};
      default: cp = '0;
    endcase

    tail = '0;
    tail_v = 1'b0;
    if (complete) begin
      tail_v = 1'b1;
      tail   = '{is_ref: 1'b1, val: cp};
    end else if (fresh_do && !fresh_hold) begin
      tail_v = 1'b1;
      tail   = '{is_ref: !fresh_plain, val: CP_W'(in_byte)};
    end

    for (int i = 0; i < ITEM_N; i++) items_b[i] = '0;
    for (int i = 0; i < HELD_N; i++) begin
      if (3'(i) < nflush) items_b[i] = '{is_ref: 1'b1, val: CP_W'(held_upd[i])};
    end
    if (tail_v) items_b[nflush[1:0]] = tail;
    nitems_b = nflush + {2'b00, tail_v};

    if (complete) hc_next = 2'd0;
    else if (extend) hc_next = string_end ? 2'd0 : hc + 2'd1;
    else hc_next = (fresh_hold) ? 2'd1 : 2'd0;
  end

  // decimal converter: one digit per step
  logic [PROD_W-1:0]          prod;
  logic [PROD_W-RECIP_SH-1:0] q;
  logic [CP_W-1:0]            q10, rem;
  item_t                      cur;

  always_comb begin
    prod = PROD_W'(conv_val) * PROD_W'(RECIP);
    q    = prod[PROD_W-1:RECIP_SH];
    q10  = CP_W'({q, 3'b000}) + CP_W'({q, 1'b0});
    rem  = conv_val - q10;
    cur  = items[idx];
  end

  always_comb begin
    sts.build_empty = (nitems_b == 3'd0);
    sts.item_ref    = cur.is_ref;
    sts.item_last   = (({1'b0, idx} + 3'd1) == nitems);
    sts.conv_last   = (q == '0);
    sts.dig_last    = (ndig == 3'd1);
    sts.slot_free   = !m_valid || m_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hc <= 2'd0;
    end else if (cmd.load) begin
      hc <= hc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < HELD_N; i++) begin
        held[i] <= ((i == 0) && fresh_do && fresh_hold) ? in_byte : held_upd[i];
      end
      for (int i = 0; i < ITEM_N; i++) items[i] <= items_b[i];
      nitems <= nitems_b;
      idx    <= 2'd0;
      end_r  <= string_end;
    end else if (cmd.item_next) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.conv_load) begin
      conv_val <= cur.val;
      ndig     <= 3'd0;
    end else if (cmd.conv_step) begin
      conv_val <= CP_W'(q);
      digs[0]  <= rem[3:0];
      for (int i = 1; i < DIG_N; i++) digs[i] <= digs[i-1];
      ndig <= ndig + 3'd1;
    end else if (cmd.push && (cmd.src == SRC_DIGIT)) begin
      for (int i = 0; i < DIG_N - 1; i++) digs[i] <= digs[i+1];
      digs[DIG_N-1] <= 4'd0;
      ndig <= ndig - 3'd1;
    end
  end

  logic       push_last;
  logic [7:0] push_byte;

  always_comb begin
    push_last = 1'b0;
    case (cmd.src)
      SRC_PLAIN: begin
        push_byte = cur.val[7:0];
        push_last = sts.item_last;
      end
      SRC_AMP:   push_byte = CH_AMP;
      SRC_HASH:  push_byte = CH_HASH;
      SRC_DIGIT: push_byte = CH_ZERO | {4'b0000, digs[0]};
      SRC_SEMI: begin
        push_byte = CH_SEMI;
        push_last = sts.item_last;
      end
      default:   push_byte = CH_SEMI;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (cmd.push) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_byte  <= push_byte;
      run_last  <= push_last;
      text_done <= push_last && end_r;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/xml_escape_utf8_to_char_ref.sv */
// ----------------------------------------------------------------------------
// XML escaper with UTF-8 numeric character references
// Escapes markup characters and turns UTF-8 sequences into &#N; text.
// ----------------------------------------------------------------------------
// channel  dir  tdata         tuser          tlast
// s_*      in   in_byte[7:0]  [0] utf8_mode  string_end
// m_*      out  out_byte[7:0] [0] text_done  run_last
//
// A plain byte is accepted and decoded, then emitted when the output is free.
// A reference with D decimal digits is accepted, loads the converter, runs the
// digit loop at one reciprocal multiply per digit, then &, #, the digits and ;
// leave one per cycle while the output is not stalled. A held lead or
// continuation byte is only accepted; it emits nothing until its sequence ends.
// Reset (rst, synchronous) clears the controller, held count and output valid.
// Output stalls hold the emitter; no input is taken until all bytes are pushed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xml_escape_utf8_to_char_ref
  import xesc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic [0:0] s_tuser,   // [0] utf8_mode
  input  wire logic       s_tlast,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic [0:0]      m_tuser,   // [0] text_done
  output logic            m_tlast
);

  cmd_t cmd;
  sts_t sts;

  xesc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .ready   (s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  xesc_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (s_tdata),
    .utf8_mode  (s_tuser[0]),
    .string_end (s_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .m_valid    (m_tvalid),
    .m_ready    (m_tready),
    .out_byte   (m_tdata),
    .run_last   (m_tlast),
    .text_done  (m_tuser[0])
  );

endmodule

`default_nettype wire

/* hw/rtl/xesc_chk.sv */
// ----------------------------------------------------------------------------
// XML escaper port checker
// Port-level properties of the escaper, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "xml_escape_utf8_to_char_ref_defines.svh"

module xesc_chk
  import xesc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic [7:0] s_tdata,
  input wire logic [0:0] s_tuser,
  input wire logic       s_tlast,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic [0:0] m_tuser,
  input wire logic       m_tlast
);

  `XESC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")
  `XESC_ASSERT_NOW(a_busy_mid_run, m_tvalid && !m_tlast, !s_tready, "input taken in the middle of a run")
  `XESC_ASSERT_NEXT(a_amp_escapes, s_tvalid && s_tready && (s_tdata == CH_AMP), !s_tready, "ampersand did not start a reference")
  `XESC_ASSERT_NOW(a_done_on_last, m_tvalid && m_tuser[0], m_tlast, "text end off a run end")
  `XESC_ASSERT_NOW(a_reset_clean, $past(rst), !m_tvalid && s_tready, "not idle after reset")

endmodule

bind xml_escape_utf8_to_char_ref xesc_chk u_xesc_chk (.*);

`default_nettype wire

/* bench/xml_escape_utf8_to_char_ref_tb.sv */
// ----------------------------------------------------------------------------
// XML escaper testbench
// Streams strings of bytes through the escaper under random valid and ready
// gaps, recomputes the escaped text for every accepted byte and compares each
// output transfer byte, run_last and text_done flag against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xml_escape_utf8_to_char_ref_tb;
  import xesc_pkg::*;

  localparam int RANDOM_ITEMS = 430;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_OUT      = 24;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       utf8_mode;
    logic       string_end;
  } src_byte_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;
  } esc_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic [0:0] s_tuser = 1'b0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [0:0] m_tuser;
  logic       m_tlast;

  src_byte_t  src_text[$];
  esc_byte_t  escaped_text[$];
  logic [7:0] step_text[$];
  logic [7:0] seq_bytes[3];
  int         seq_count = 0;
  int         in_taken = 0;
  int         total_items = 0;
  int         stall_cycles = 0;
  int         fail_count = 0;
  logic       calm;

  xml_escape_utf8_to_char_ref dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  assign calm = (in_taken >= 180) && (in_taken < 260);

  function automatic int utf8_len(input logic [7:0] lead);
    casez (lead)
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 0;
    endcase
  endfunction

  task automatic emit(input logic [7:0] b);
    if (step_text.size() < MAX_OUT) step_text.push_back(b);
  endtask

  task automatic emit_ref(input int unsigned v);
    string digits;
    digits = $sformatf("%0d", v);
    emit(CH_AMP);
    emit(CH_HASH);
    for (int i = 0; i < digits.len(); i++) emit(digits[i]);
    emit(CH_SEMI);
  endtask

  task automatic flush_seq();
    for (int i = 0; i < seq_count; i++) emit_ref(seq_bytes[i]);
    seq_count = 0;
  endtask

  // work out the escaped bytes caused by one source byte
  task automatic escape_step(input logic [7:0] b, input logic mode, input logic fin);
    int          need;
    logic [20:0] cp;
    step_text.delete();
    if (seq_count > 0 && (!mode || b[7:6] != 2'b10)) flush_seq();
    if (seq_count > 0) begin
      need = utf8_len(seq_bytes[0]);
      if (seq_count + 1 == need) begin
        case (need)
          2: cp = {seq_bytes[0][4:0], b[5:0]};
          3: cp = {seq_bytes[0][3:0], seq_bytes[1][5:0], b[5:0]};
          default: cp = {seq_bytes[0][2:0], seq_bytes[1][5:0], seq_bytes[2][5:0], b[5:0]};
        endcase
        seq_count = 0;
        emit_ref(cp);
      end else if (seq_count + 1 < need && seq_count < 3) begin
        seq_bytes[seq_count] = b;
        seq_count++;
        if (fin) flush_seq();
      end else begin
        flush_seq();
        emit_ref(b);
      end
    end else if (b == CH_AMP || b == CH_LT || b == CH_GT || b == CH_APOS || b == CH_QUOT) begin
      emit_ref(b);
    end else if (!mode || !b[7]) begin
      emit(b);
    end else if (utf8_len(b) != 0 && !fin) begin
      seq_bytes[0] = b;
      seq_count = 1;
    end else begin
      emit_ref(b);
    end
    if (fin && seq_count > 0) flush_seq();
    foreach (step_text[i]) begin
      escaped_text.push_back({step_text[i], i == step_text.size() - 1,
                              (i == step_text.size() - 1) && fin});
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic mode, input logic fin);
    src_text.push_back({b, mode, fin});
  endtask

  // source side: present the next byte, idle at random
  always @(posedge clk) begin
    src_byte_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (src_text.size() > 0 && (calm || $urandom_range(0, 99) >= 18)) begin
        nxt = src_text.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= nxt.in_byte;
        s_tuser  <= nxt.utf8_mode;
        s_tlast  <= nxt.string_end;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // sink side: stall at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(0, 99) >= 18);
    end
  end

  // predict on every input transfer, check every output transfer
  always @(posedge clk) begin
    esc_byte_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        escape_step(s_tdata, s_tuser[0], s_tlast);
        in_taken <= in_taken + 1;
      end
      if (m_tvalid && m_tready) begin
        if (escaped_text.size() == 0) begin
          $error("unexpected transfer: out_byte %h run_last %b text_done %b",
                 m_tdata, m_tlast, m_tuser[0]);
          fail_count++;
        end else begin
          want = escaped_text.pop_front();
          if (m_tdata !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, m_tdata);
            fail_count++;
          end
          if (m_tlast !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, m_tlast);
            fail_count++;
          end
          if (m_tuser[0] !== want.text_done) begin
            $error("text_done: expected %b, got %b", want.text_done, m_tuser[0]);
            fail_count++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("** xml_escape_utf8_to_char_ref: FAILED **");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [7:0] piece[$];
    logic [7:0] lead;
    logic       mode;
    int         kind;
    int         len;
    int         cut;
    int         target;
    int         n;
    int         directed_n;

    // markup characters, stray and invalid bytes, complete sequences
    queue_byte(CH_LT, 1'b1, 1'b0);
    queue_byte(CH_GT, 1'b1, 1'b0);
    queue_byte(CH_APOS, 1'b1, 1'b0);
    queue_byte(CH_QUOT, 1'b1, 1'b0);
    queue_byte(8'h80, 1'b1, 1'b0);
    queue_byte(8'hF8, 1'b1, 1'b0);
    queue_byte(8'hC0, 1'b1, 1'b0);
    queue_byte(8'h80, 1'b1, 1'b0);
    queue_byte(8'hE2, 1'b1, 1'b0);
    queue_byte(8'h82, 1'b1, 1'b0);
    queue_byte(8'hAC, 1'b1, 1'b0);
    queue_byte(8'hF7, 1'b1, 1'b0);
    queue_byte(8'hBF, 1'b1, 1'b0);
    queue_byte(8'hBF, 1'b1, 1'b0);
    queue_byte(8'hBF, 1'b1, 1'b0);
    // broken sequence, then incomplete at string end
    queue_byte(8'hF0, 1'b1, 1'b0);
    queue_byte(8'h90, 1'b1, 1'b0);
    queue_byte(8'h41, 1'b1, 1'b0);
    queue_byte(8'hE2, 1'b1, 1'b0);
    queue_byte(8'h82, 1'b1, 1'b1);
    // mode dropped while a lead is held, zero byte, high bytes passed through
    queue_byte(8'hC3, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(CH_AMP, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b1);
    // lead byte at string end
    queue_byte(8'hC3, 1'b1, 1'b1);

    directed_n = src_text.size();
    while (src_text.size() < directed_n + RANDOM_ITEMS) begin
      mode = ($urandom_range(0, 99) < 80);
      target = $urandom_range(1, 12);
      n = 0;
      while (n < target) begin
        piece.delete();
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
          piece.push_back(8'($urandom_range(0, 127)));
        end else if (kind < 40) begin
          case ($urandom_range(0, 4))
            0: piece.push_back(CH_AMP);
            1: piece.push_back(CH_LT);
            2: piece.push_back(CH_GT);
            3: piece.push_back(CH_APOS);
            default: piece.push_back(CH_QUOT);
          endcase
        end else if (kind < 88) begin
          len = $urandom_range(2, 4);
          case (len)
            2: lead = 8'hC0 | 8'($urandom_range(0, 31));
            3: lead = 8'hE0 | 8'($urandom_range(0, 15));
            default: lead = 8'hF0 | 8'($urandom_range(0, 7));
          endcase
          piece.push_back(lead);
          cut = (kind < 80) ? len - 1 : $urandom_range(0, len - 2);
          repeat (cut) piece.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end else if (kind < 94) begin
          piece.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else begin
          piece.push_back(8'($urandom_range(8'hF8, 8'hFF)));
        end
        foreach (piece[i]) begin
          queue_byte(piece[i], ($urandom_range(0, 99) < 3) ? !mode : mode, 1'b0);
        end
        n += piece.size();
      end
      src_text[src_text.size() - 1].string_end = 1'b1;
    end
    total_items = src_text.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (in_taken < total_items || escaped_text.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && escaped_text.size() == 0) begin
      $display("** xml_escape_utf8_to_char_ref: PASSED **");
    end else begin
      $display("** xml_escape_utf8_to_char_ref: FAILED **");
    end
    $finish;
  end

endmodule
